### rtl/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

  // Field widths of the request, result and configuration channels.
  localparam int ACTION_W   = 2;
  localparam int START_W    = 14;
  localparam int COUNT_W    = 15;
  localparam int FIRST_W    = 14;
  localparam int LIMIT_W    = 15;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 15'd16384;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 1'b0;

  // Request action codes; code 3 is accepted and does nothing.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_MARK  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FILL_RD,
    S_FILL_WR,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic latch;
    logic setup;
    logic scan_rd;
    logic scan_ev;
    logic fill_rd;
    logic fill_wr;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t act;
    logic    cnt_zero;
    logic    fill_empty;
    logic    pos_at_lim;
    logic    scan_hit;
    logic    scan_ok;
    logic    fill_last;
    logic    clr_last;
  } dp_status_t;

endpackage

### rtl/bfa_chan_if.sv
// Request and result channel interfaces of the bitmap frame allocator.
interface bfa_req_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [START_W-1:0]  start_frame;
  logic [COUNT_W-1:0]  frame_count;

  modport source (output valid, action, start_frame, frame_count, input ready);
  modport sink   (input valid, action, start_frame, frame_count, output ready);
endinterface

interface bfa_rsp_if;
  import bfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIRST_W-1:0] first_frame;
  logic               failed;

  modport source (output valid, first_frame, failed, input ready);
  modport sink   (input valid, first_frame, failed, output ready);
endinterface

### rtl/bitmap_frame_allocator.sv
// Top level of the bitmap frame allocator: channels, configuration port and submodules.
// The allocator keeps one used bit per frame in a memory of WORD_BITS-wide words
// (WORD_BITS a power of two) and a forward-only search pointer. After reset a
// clearing pass writes every bitmap word, one per cycle; no request is accepted
// until it ends, while configuration writes are taken at any time. Requests are
// handled one at a time. Free and mark read and write back each bitmap word
// touched; action 3 and a zero-length allocate touch no bitmap word. An allocate
// reads each word scanned, reads a word again after each used frame met inside it,
// then reads and writes back each word of the run it marks, all through the
// single-port bitmap memory with its registered read. A finished result waits in
// an output register, so the next request can be accepted before the previous
// result is taken.
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES = 16384,
  parameter int WORD_BITS  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  bfa_req_if.sink                           req,
  bfa_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfa_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bfa_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import bfa_pkg::*;

  localparam int FW = $clog2(NUM_FRAMES + 1);

  logic [LIMIT_W-1:0]   frame_limit;
  logic [31:0]          lim_w;
  logic [FW-1:0]        lim;
  logic                 cfg_wr;
  logic                 req_ready;
  logic                 rsp_valid;
  dp_cmd_t              cmd;
  dp_status_t           st;

  // Configuration register: frame limit.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_FRAME_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      frame_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_FRAME_LIMIT) ?
                  CFG_DATA_W'(frame_limit) : '0;

  // Effective limit is the smaller of the register and the store size.
  assign lim_w = 32'(frame_limit);
  assign lim   = (lim_w < 32'(NUM_FRAMES)) ? FW'(lim_w) : FW'(NUM_FRAMES);

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .lim        (lim),
    .in_action  (req.action),
    .in_start   (req.start_frame),
    .in_count   (req.frame_count),
    .out_first  (rsp.first_frame),
    .out_failed (rsp.failed)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

endmodule

### rtl/bfa_ctrl.sv
// Controller state machine of the bitmap frame allocator.
module bfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  bfa_pkg::dp_status_t st,
  output bfa_pkg::dp_cmd_t    cmd
);
  import bfa_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (st.act) inside
          ACT_ALLOC: state_next = st.cnt_zero ? S_DONE : S_SCAN_RD;
          ACT_FREE, ACT_MARK: state_next = st.fill_empty ? S_DONE : S_FILL_RD;
          default: state_next = S_DONE;
        endcase
      end
      S_SCAN_RD: begin
        state_next = st.pos_at_lim ? S_DONE : S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (st.scan_hit) state_next = S_SCAN_RD;
        else if (st.scan_ok) state_next = S_FILL_RD;
        else state_next = S_SCAN_RD;
      end
      S_FILL_RD: begin
        state_next = S_FILL_WR;
      end
      S_FILL_WR: begin
        state_next = st.fill_last ? S_DONE : S_FILL_RD;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_CLEAR:   cmd.clear = 1'b1;
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      S_DECODE:  cmd.setup = 1'b1;
      S_SCAN_RD: cmd.scan_rd = 1'b1;
      S_SCAN_EV: cmd.scan_ev = 1'b1;
      S_FILL_RD: cmd.fill_rd = 1'b1;
      S_FILL_WR: cmd.fill_wr = 1'b1;
      S_DONE:    cmd.load_out = !rsp_valid || rsp_ready;
      default:   cmd = '0;
    endcase
  end

  // Result valid flag: set when a result is loaded, cleared by its transfer.
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.load_out) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### rtl/bfa_datapath.sv
// Datapath of the bitmap frame allocator: bitmap memory, search pointer and range logic.
module bfa_datapath #(
  parameter  int NUM_FRAMES = 16384,
  parameter  int WORD_BITS  = 64,
  localparam int FW         = $clog2(NUM_FRAMES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfa_pkg::dp_cmd_t              cmd,
  output bfa_pkg::dp_status_t           st,
  input  logic [FW-1:0]                 lim,
  input  logic [bfa_pkg::ACTION_W-1:0]  in_action,
  input  logic [bfa_pkg::START_W-1:0]   in_start,
  input  logic [bfa_pkg::COUNT_W-1:0]   in_count,
  output logic [bfa_pkg::FIRST_W-1:0]   out_first,
  output logic                          out_failed
);
  import bfa_pkg::*;

  localparam int XW        = ((FW > COUNT_W) ? FW : COUNT_W) + 1;
  localparam int WSH       = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [XW-1:0] FRAMES_X = XW'(NUM_FRAMES);
  localparam logic [XW-1:0] WORD_X   = XW'(WORD_BITS);

  // Bitmap store, one bit per frame, set means used.
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] wdata;

  // Request and scan registers.
  action_t              act_r;
  logic [START_W-1:0]   start_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic [FW-1:0]        ptr;
  logic [XW-1:0]        pos;
  logic [XW-1:0]        stop;
  logic                 set_r;
  logic [FIRST_W-1:0]   first_r;
  logic                 failed_r;
  logic [AW-1:0]        clr_idx;

  logic [XW-1:0]        ptr_x;
  logic [XW-1:0]        lim_x;
  logic [XW-1:0]        start_x;
  logic [XW-1:0]        cnt_x;
  logic [XW-1:0]        base;
  logic [XW-1:0]        wend;
  logic [XW-1:0]        cap;
  logic [XW-1:0]        span;
  logic [XW-1:0]        nxt;
  logic [XW-1:0]        range_end;
  logic [XW-1:0]        fill_end;
  logic [WSH-1:0]       off;
  logic [WSH-1:0]       idx;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hit;
  logic                 hit_any;
  logic [AW-1:0]        word_idx;

  assign ptr_x    = XW'(ptr);
  assign lim_x    = XW'(lim);
  assign start_x  = XW'(start_r);
  assign cnt_x    = XW'(cnt_r);
  assign word_idx = pos[WSH +: AW];
  assign off      = pos[WSH-1:0];
  assign base     = {pos[XW-1:WSH], {WSH{1'b0}}};
  assign wend     = base + WORD_X;

  // Window of the current word: from pos up to the word end, the range end
  // and, while scanning, the frame limit.
  always_comb begin
    cap = wend;
    if (cmd.scan_ev && (lim_x < cap)) cap = lim_x;
    if (stop < cap) cap = stop;
  end

  assign span = cap - base;
  assign mask = ~({WORD_BITS{1'b1}} << span[WSH:0]) & ({WORD_BITS{1'b1}} << off);
  assign hit  = rdata & mask;
  assign hit_any = |hit;

  // Lowest used frame inside the window.
  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit[i]) idx = WSH'(i);
    end
  end

  assign nxt       = base + XW'(idx) + XW'(1);
  assign range_end = start_x + cnt_x;
  assign fill_end  = (range_end < FRAMES_X) ? range_end : FRAMES_X;
  assign wdata     = set_r ? (rdata | mask) : (rdata & ~mask);

  // Status toward the controller.
  always_comb begin
    st.act        = act_r;
    st.cnt_zero   = (cnt_r == '0);
    st.fill_empty = (cnt_r == '0) || (start_x >= FRAMES_X);
    st.pos_at_lim = (pos >= lim_x);
    st.scan_hit   = hit_any;
    st.scan_ok    = !hit_any && (cap == stop);
    st.fill_last  = (cap == stop);
    st.clr_last   = (clr_idx == AW'(MAP_WORDS - 1));
  end

  // Bitmap memory: clearing pass, read-modify-write of ranges, registered read.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_idx] <= '0;
    end else if (cmd.fill_wr) begin
      mem[word_idx] <= wdata;
    end
    if (cmd.scan_rd || cmd.fill_rd) begin
      rdata <= mem[word_idx];
    end
  end

  // Search pointer and clearing counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= FW'(1);
      clr_idx <= '0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + AW'(1);
      if (cmd.scan_ev && hit_any) ptr <= nxt[FW-1:0];
    end
  end

  // Request fields, scan position and result registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= action_t'(in_action);
      start_r <= in_start;
      cnt_r   <= in_count;
    end
    if (cmd.setup) begin
      first_r  <= '0;
      failed_r <= 1'b0;
      set_r    <= (act_r == ACT_MARK);
      case (act_r) inside
        ACT_ALLOC: begin
          pos  <= ptr_x;
          stop <= ptr_x + cnt_x;
          if (cnt_r == '0) begin
            if (ptr_x < lim_x) first_r <= ptr_x[FIRST_W-1:0];
            else failed_r <= 1'b1;
          end
        end
        ACT_FREE, ACT_MARK: begin
          pos  <= start_x;
          stop <= fill_end;
        end
        default: begin
          pos <= pos;
        end
      endcase
    end
    if (cmd.scan_rd && (pos >= lim_x)) begin
      failed_r <= 1'b1;
    end
    if (cmd.scan_ev) begin
      if (hit_any) begin
        // Used frame met: restart the run just past it.
        pos  <= nxt;
        stop <= nxt + cnt_x;
      end else if (cap == stop) begin
        // Run found: go back to its start and mark it used.
        first_r <= ptr_x[FIRST_W-1:0];
        pos     <= ptr_x;
        set_r   <= 1'b1;
      end else begin
        pos <= cap;
      end
    end
    if (cmd.fill_wr) begin
      pos <= cap;
    end
    if (cmd.load_out) begin
      out_first  <= first_r;
      out_failed <= failed_r;
    end
  end

endmodule

### rtl/bfa_checker.sv
// Port-level assertions of the bitmap frame allocator and their binding.
module bfa_sva (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [bfa_pkg::FIRST_W-1:0]  first_frame,
  input logic                         failed
);
  import bfa_pkg::*;

  // The clearing pass blocks requests right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during the clearing pass");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  // A failed allocation reports frame zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && failed |-> first_frame == '0)
    else $error("failed result with nonzero first frame");

  // A stalled result holds until its transfer.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(first_frame) && $stable(failed))
    else $error("result changed before its transfer");

endmodule

bind bitmap_frame_allocator bfa_sva u_bfa_sva (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .first_frame (rsp.first_frame),
  .failed      (rsp.failed)
);
